[src/csoc_pkg.sv]
// shared types, constants and codes for the column span occlusion clipper
package csoc_pkg;

  localparam int CANVAS_WIDTH = 512;
  localparam int CLIP_AW      = $clog2(CANVAS_WIDTH);
  localparam int COORD_MAX    = 4095;

  localparam int IN_W   = 112;
  localparam int OUT_W  = 72;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 13;

  localparam logic [31:0] SOLID_COLOR  = 32'h00FF_FFFF;
  localparam logic [31:0] PORTAL_COLOR = 32'h00FF_00FF;

  localparam logic [3:0]  SCALE_X_RST       = 4'd1;
  localparam logic [3:0]  SCALE_Y_RST       = 4'd1;
  localparam logic [12:0] WIN_COLS_RST      = 13'd640;
  localparam logic [12:0] WIN_ROWS_RST      = 13'd400;
  localparam logic [12:0] CANVAS_HEIGHT_RST = 13'd200;
  localparam logic [15:0] CLR_FLOOR_RST     = {3'b000, CANVAS_HEIGHT_RST} - 16'd1;

  typedef enum logic {
    OP_CLEAR  = 1'b0,
    OP_COLUMN = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    WALL_SOLID  = 2'd0,
    WALL_PORTAL = 2'd1,
    WALL_DOOR   = 2'd2
  } wall_kind_t;

  typedef enum logic [1:0] {
    SPAN_FLOOR  = 2'd0,
    SPAN_CEIL   = 2'd1,
    SPAN_SOLID  = 2'd2,
    SPAN_PORTAL = 2'd3
  } span_kind_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_SCALE_X       = 3'd0,
    REG_SCALE_Y       = 3'd1,
    REG_WIN_COLS      = 3'd2,
    REG_WIN_ROWS      = 3'd3,
    REG_CANVAS_HEIGHT = 3'd4
  } reg_idx_t;

  // clip update steps of one column item
  typedef enum logic [1:0] {
    PH_FLOOR = 2'd0,
    PH_CEIL  = 2'd1,
    PH_WALL  = 2'd2,
    PH_LOWER = 2'd3
  } phase_t;

  typedef struct packed {
    logic [3:0]  scale_x;
    logic [3:0]  scale_y;
    logic [12:0] win_cols;
    logic [12:0] win_rows;
    logic [12:0] canvas_height;
  } cfg_t;

  // last field in the lowest bits
  typedef struct packed {
    logic [4:0]         rsvd;
    logic [31:0]        side_color;
    logic signed [15:0] next_ceiling_row;
    logic signed [15:0] next_floor_row;
    logic [1:0]         wall_kind;
    logic signed [15:0] ceiling_row;
    logic signed [15:0] floor_row;
    logic [8:0]         column;
  } in_data_t;

  typedef struct packed {
    logic [3:0]  rsvd;
    logic [31:0] span_color;
    logic [11:0] span_bottom;
    logic [11:0] span_top;
    logic [11:0] span_x;
  } out_data_t;

  typedef struct packed {
    logic   clr_go;
    logic   clr_start;
    logic   rd_load;
    logic   phase_go;
    logic   first;
    phase_t phase;
    logic   drain;
    logic   flush;
  } cmd_t;

  typedef struct packed {
    logic stall;
    logic clr_last;
    logic hold_vld;
    logic out_free;
    logic col_ok;
  } sts_t;

endpackage

[src/column_span_occlusion_clipper_top.sv]
// A column item runs through these steps, transfer to transfer, when the output is not held off: an
// accept step that reads the column's clip pair from the single-port clip memory, four update
// steps (floor, ceiling, wall, lower portal wall) through one shared clip update unit, one
// step that writes the pair back, and one that releases the final span with tlast. Output
// back-pressure stalls the item when a new span finds both the hold register and the output
// register occupied, and when the final span waits for the output register to free up.
// A clear item takes an accept step and a sweep of all 512 clip entries, one clip entry per cycle,
// and the same sweep runs after reset with in_tready low; configuration writes are taken at any time.
module column_span_occlusion_clipper_top
  import csoc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // column, floor_row, ceiling_row, wall_kind, next_floor_row, next_ceiling_row, side_color
  input  logic [IN_W-1:0]   in_tdata,
  // opcode
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // span_x, span_top, span_bottom, span_color
  output logic [OUT_W-1:0]  out_tdata,
  // span_kind
  output logic [1:0]        out_tuser,
  output logic              out_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  csoc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  csoc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  csoc_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[src/csoc_cfg.sv]
// configuration register file
module csoc_cfg
  import csoc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output cfg_t              cfg
);

  logic [3:0]  scale_x_r;
  logic [3:0]  scale_y_r;
  logic [12:0] win_cols_r;
  logic [12:0] win_rows_r;
  logic [12:0] canvas_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r       <= SCALE_X_RST;
      scale_y_r       <= SCALE_Y_RST;
      win_cols_r      <= WIN_COLS_RST;
      win_rows_r      <= WIN_ROWS_RST;
      canvas_height_r <= CANVAS_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCALE_X:       scale_x_r       <= cfg_data[3:0];
        REG_SCALE_Y:       scale_y_r       <= cfg_data[3:0];
        REG_WIN_COLS:      win_cols_r      <= cfg_data[12:0];
        REG_WIN_ROWS:      win_rows_r      <= cfg_data[12:0];
        REG_CANVAS_HEIGHT: canvas_height_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.scale_x       = scale_x_r;
    cfg.scale_y       = scale_y_r;
    cfg.win_cols      = win_cols_r;
    cfg.win_rows      = win_rows_r;
    cfg.canvas_height = canvas_height_r;
  end

endmodule

[src/csoc_ctrl.sv]
// controller state machine: clear sweep, clip update steps, span drain
module csoc_ctrl
  import csoc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tuser,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_PHASE = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  phase_t ph_r, ph_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ph_r    <= PH_FLOOR;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    in_tready     = 1'b0;
    cmd.clr_go    = 1'b0;
    cmd.clr_start = 1'b0;
    cmd.rd_load   = 1'b0;
    cmd.phase_go  = 1'b0;
    cmd.first     = (ph_r == PH_FLOOR);
    cmd.phase     = ph_r;
    cmd.drain     = 1'b0;
    cmd.flush     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_go = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == OP_CLEAR) begin
            cmd.clr_start = 1'b1;
            state_nxt     = ST_CLEAR;
          end else if (sts.col_ok) begin
            cmd.rd_load = 1'b1;
            ph_nxt      = PH_FLOOR;
            state_nxt   = ST_PHASE;
          end
        end
      end
      ST_PHASE: begin
        cmd.phase_go = !sts.stall;
        if (!sts.stall) begin
          case (ph_r)
            PH_FLOOR: ph_nxt = PH_CEIL;
            PH_CEIL:  ph_nxt = PH_WALL;
            PH_WALL:  ph_nxt = PH_LOWER;
            PH_LOWER: state_nxt = ST_DRAIN;
            default:  state_nxt = ST_DRAIN;
          endcase
        end
      end
      ST_DRAIN: begin
        // clip entry is final here, write it back while the last span settles
        cmd.drain = 1'b1;
        if (!sts.stall) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (!sts.hold_vld || sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[src/csoc_datapath.sv]
// datapath: clip memory, clip update unit, span scaling and output registers
module csoc_datapath
  import csoc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  in_data_t in_d;

  logic [31:0] clip_mem [CANVAS_WIDTH];
  logic [31:0] rd_data_r;
  logic [CLIP_AW-1:0] clr_cnt_r;
  logic [15:0] clr_val_r;
  logic clr_last;

  // latched column item
  logic [8:0]         col_r;
  logic signed [15:0] fr_r, cr_r, nfr_r, ncr_r;
  logic [1:0]         wkind_r;
  logic [31:0]        color_r;

  // working clip pair
  logic signed [15:0] fc_r, cc_r;
  logic signed [15:0] w_fc, w_cc, fc_nxt, cc_nxt;
  logic signed [15:0] top, bot_s, bot_p, lb;

  logic               ph_vld;
  logic signed [16:0] ph_y0, ph_y1;
  span_kind_t         ph_kind;

  logic               raw_vld_r;
  logic signed [16:0] raw_y0_r, raw_y1_r;
  span_kind_t         raw_kind_r;

  logic [12:0]        sx;
  logic signed [21:0] t0, t1;
  logic               x_ok, keep, stall, out_free;
  logic [11:0]        s_top, s_bot;
  logic [31:0]        s_color;

  logic               hold_vld_r;
  logic [11:0]        hold_x_r, hold_top_r, hold_bot_r;
  logic [31:0]        hold_color_r;
  span_kind_t         hold_kind_r;

  logic               out_vld_r, out_last_r;
  logic [11:0]        out_x_r, out_top_r, out_bot_r;
  logic [31:0]        out_color_r;
  span_kind_t         out_kind_r;
  logic               move_mid, move_last;
  out_data_t          od;

  function automatic logic row_ok(input logic signed [21:0] t, input logic [12:0] wh);
    row_ok = !t[21] && (wh != 13'd0) && (t[20:0] <= 21'(wh - 13'd1))
             && (int'(t[20:0]) <= COORD_MAX);
  endfunction

  assign in_d = in_data_t'(in_tdata);

  // clear sweep address
  assign clr_last = (clr_cnt_r == CLIP_AW'(CANVAS_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      clr_val_r <= CLR_FLOOR_RST;
    end else begin
      if (cmd.clr_start) clr_val_r <= {3'b000, cfg.canvas_height} - 16'd1;
      if (cmd.clr_go) clr_cnt_r <= clr_last ? '0 : clr_cnt_r + 1'b1;
    end
  end

  // clip memory: ceiling in the upper half, floor in the lower half
  always_ff @(posedge clk) begin
    if (cmd.clr_go) begin
      clip_mem[clr_cnt_r] <= {16'd0, clr_val_r};
    end else if (cmd.drain) begin
      clip_mem[CLIP_AW'(col_r)] <= {cc_r, fc_r};
    end
    if (cmd.rd_load) rd_data_r <= clip_mem[CLIP_AW'(in_d.column)];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_load) begin
      col_r   <= in_d.column;
      fr_r    <= in_d.floor_row;
      cr_r    <= in_d.ceiling_row[15] ? 16'sd0 : in_d.ceiling_row;
      nfr_r   <= in_d.next_floor_row;
      ncr_r   <= in_d.next_ceiling_row;
      wkind_r <= in_d.wall_kind;
      color_r <= in_d.side_color;
    end
    if (cmd.phase_go) begin
      fc_r <= fc_nxt;
      cc_r <= cc_nxt;
    end
  end

  // one clip update step per cycle while the span output does not stall
  always_comb begin
    w_fc    = cmd.first ? $signed(rd_data_r[15:0])  : fc_r;
    w_cc    = cmd.first ? $signed(rd_data_r[31:16]) : cc_r;
    top     = (cr_r > w_cc)  ? cr_r  : w_cc;
    bot_s   = (fr_r < w_fc)  ? fr_r  : w_fc;
    bot_p   = (ncr_r < w_fc) ? ncr_r : w_fc;
    lb      = (nfr_r > w_cc) ? nfr_r : w_cc;
    fc_nxt  = w_fc;
    cc_nxt  = w_cc;
    ph_vld  = 1'b0;
    ph_y0   = 17'sd0;
    ph_y1   = 17'sd0;
    ph_kind = SPAN_FLOOR;
    case (cmd.phase)
      PH_FLOOR: begin
        if (w_fc >= fr_r) begin
          ph_vld = 1'b1;
          ph_y0  = 17'(w_fc) - 17'sd1;
          ph_y1  = 17'(fr_r);
          fc_nxt = fr_r;
        end
      end
      PH_CEIL: begin
        ph_kind = SPAN_CEIL;
        if (w_cc <= cr_r) begin
          ph_vld = 1'b1;
          ph_y0  = 17'(w_cc) + 17'sd1;
          ph_y1  = 17'(cr_r);
          cc_nxt = cr_r;
        end
      end
      PH_WALL: begin
        if (wkind_r == WALL_SOLID) begin
          ph_kind = SPAN_SOLID;
          ph_y0   = 17'(top);
          ph_y1   = 17'(bot_s);
          if (top <= bot_s) begin
            ph_vld = 1'b1;
            cc_nxt = top;
            fc_nxt = bot_s;
          end
        end else if (wkind_r == WALL_PORTAL && ncr_r > cr_r) begin
          // upper portal wall
          ph_kind = SPAN_PORTAL;
          ph_y0   = 17'(top);
          ph_y1   = 17'(bot_p);
          if (top < bot_p) begin
            ph_vld = 1'b1;
            cc_nxt = bot_p;
          end else begin
            cc_nxt = top;
          end
        end
      end
      PH_LOWER: begin
        ph_kind = SPAN_PORTAL;
        ph_y0   = 17'(lb);
        ph_y1   = 17'(bot_s);
        if (wkind_r == WALL_PORTAL && nfr_r < fr_r) begin
          if (lb < bot_s) begin
            ph_vld = 1'b1;
            fc_nxt = lb;
          end else begin
            fc_nxt = bot_s;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_vld_r <= 1'b0;
    end else if (cmd.phase_go) begin
      raw_vld_r <= ph_vld;
    end else if (!stall) begin
      raw_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.phase_go) begin
      raw_y0_r   <= ph_y0;
      raw_y1_r   <= ph_y1;
      raw_kind_r <= ph_kind;
    end
  end

  // scale to window coordinates and bounds check
  always_comb begin
    sx = {4'b0000, col_r} * {9'd0, cfg.scale_x};
    t0 = 22'($signed({1'b0, cfg.scale_y})) * 22'(raw_y0_r);
    t1 = 22'($signed({1'b0, cfg.scale_y})) * 22'(raw_y1_r);
    x_ok = (cfg.win_cols != 13'd0) && (sx <= cfg.win_cols - 13'd1)
           && (int'(sx) <= COORD_MAX);
    keep  = raw_vld_r && x_ok && row_ok(t0, cfg.win_rows)
            && row_ok(t1, cfg.win_rows);
    s_top = (t0 < t1) ? t0[11:0] : t1[11:0];
    s_bot = (t0 < t1) ? t1[11:0] : t0[11:0];
    case (raw_kind_r)
      SPAN_FLOOR, SPAN_CEIL: s_color = color_r;
      SPAN_SOLID:            s_color = SOLID_COLOR;
      default:               s_color = PORTAL_COLOR;
    endcase
  end

  // a kept span waits in hold until the next one shows whether it is the last
  assign out_free  = !out_vld_r || out_tready;
  assign stall     = keep && hold_vld_r && !out_free;
  assign move_mid  = keep && hold_vld_r && out_free;
  assign move_last = cmd.flush && hold_vld_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (keep && !stall) begin
      hold_vld_r <= 1'b1;
    end else if (move_last) begin
      hold_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (keep && !stall) begin
      hold_x_r     <= sx[11:0];
      hold_top_r   <= s_top;
      hold_bot_r   <= s_bot;
      hold_color_r <= s_color;
      hold_kind_r  <= raw_kind_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (move_mid || move_last) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_mid || move_last) begin
      out_x_r     <= hold_x_r;
      out_top_r   <= hold_top_r;
      out_bot_r   <= hold_bot_r;
      out_color_r <= hold_color_r;
      out_kind_r  <= hold_kind_r;
      out_last_r  <= move_last;
    end
  end

  always_comb begin
    od.rsvd        = 4'd0;
    od.span_color  = out_color_r;
    od.span_bottom = out_bot_r;
    od.span_top    = out_top_r;
    od.span_x      = out_x_r;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = od;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    sts.stall    = stall;
    sts.clr_last = clr_last;
    sts.hold_vld = hold_vld_r;
    sts.out_free = out_free;
    sts.col_ok   = (int'(in_d.column) < CANVAS_WIDTH);
  end

endmodule

[src/csoc_checker.sv]
// port-level checker for the clipper top level, with its bind
module csoc_checker
  import csoc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata,
  input logic [1:0]        out_tuser,
  input logic              out_tlast
);

  out_data_t od;
  assign od = out_data_t'(out_tdata);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled output transfer changed");

  a_solid_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == SPAN_SOLID |-> od.span_color == SOLID_COLOR)
    else $error("solid wall span with wrong color");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> od.span_top <= od.span_bottom)
    else $error("span top below span bottom");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_CLEAR |=> !in_tready)
    else $error("input taken during clear sweep");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind column_span_occlusion_clipper_top csoc_checker u_csoc_checker (.*);

[verif/testbench.sv]
// self-checking testbench for the column span occlusion clipper: stream driver, span checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import csoc_pkg::*;

  // wall kind with no name of its own, handled like a door
  localparam logic [1:0] WALL_KIND_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 600;

  typedef struct {
    opcode_t  op;
    in_data_t d;
  } col_item_t;

  typedef struct {
    logic [11:0] x;
    logic [11:0] top;
    logic [11:0] bot;
    logic [31:0] color;
    span_kind_t  kind;
    logic        last;
  } span_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // column, floor_row, ceiling_row, wall_kind, next_floor_row, next_ceiling_row, side_color
  logic [IN_W-1:0]   in_tdata = '0;
  // opcode
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // span_x, span_top, span_bottom, span_color
  logic [OUT_W-1:0]  out_tdata;
  // span_kind
  logic [1:0]        out_tuser;
  logic              out_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  column_span_occlusion_clipper_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of registers and clip rows
  logic [3:0]  scale_x_m;
  logic [3:0]  scale_y_m;
  logic [12:0] win_w_m;
  logic [12:0] win_h_m;
  logic [12:0] canvas_h_m;
  int          ceil_store [CANVAS_WIDTH];
  int          floor_store [CANVAS_WIDTH];

  col_item_t   col_items[$];
  span_t       span_expect[$];
  col_item_t   presented;

  int send_idle_pct = 26;
  int recv_stall_pct = 76;
  int fail_count = 0;
  int spans_checked = 0;
  int columns_sent = 0;
  int clears_sent = 0;
  int settings_run = 0;

  function automatic void clear_clip_store();
    for (int i = 0; i < CANVAS_WIDTH; i++) begin
      ceil_store[i] = 0;
      floor_store[i] = int'(canvas_h_m) - 1;
    end
  endfunction

  // scale one span to window coordinates, drop it when it leaves the window
  function automatic void push_span(int col, int y0, int y1, logic [31:0] color,
                                    span_kind_t kind);
    int    sx, t0, t1, wmax, hmax, tmp;
    span_t s;
    sx = int'(scale_x_m) * col;
    t0 = int'(scale_y_m) * y0;
    t1 = int'(scale_y_m) * y1;
    wmax = int'(win_w_m) - 1;
    if (wmax > COORD_MAX) wmax = COORD_MAX;
    hmax = int'(win_h_m) - 1;
    if (hmax > COORD_MAX) hmax = COORD_MAX;
    if (sx < 0 || sx > wmax) return;
    if (t0 < 0 || t0 > hmax || t1 < 0 || t1 > hmax) return;
    if (t0 > t1) begin
      tmp = t0;
      t0 = t1;
      t1 = tmp;
    end
    s.x = sx[11:0];
    s.top = t0[11:0];
    s.bot = t1[11:0];
    s.color = color;
    s.kind = kind;
    s.last = 1'b0;
    span_expect.push_back(s);
  endfunction

  function automatic void predict_column_spans(col_item_t it);
    int    col, fr, cr, nfr, ncr, top, bot, lb, lt, base;
    span_t s;
    if (it.op == OP_CLEAR) begin
      clear_clip_store();
      return;
    end
    col = int'(it.d.column);
    fr = int'($signed(it.d.floor_row));
    cr = int'($signed(it.d.ceiling_row));
    nfr = int'($signed(it.d.next_floor_row));
    ncr = int'($signed(it.d.next_ceiling_row));
    base = span_expect.size();
    if (cr < 0) cr = 0;
    if (floor_store[col] >= fr) begin
      push_span(col, floor_store[col] - 1, fr, it.d.side_color, SPAN_FLOOR);
      floor_store[col] = fr;
    end
    if (ceil_store[col] <= cr) begin
      push_span(col, ceil_store[col] + 1, cr, it.d.side_color, SPAN_CEIL);
      ceil_store[col] = cr;
    end
    if (it.d.wall_kind == WALL_SOLID) begin
      top = (cr > ceil_store[col]) ? cr : ceil_store[col];
      bot = (fr < floor_store[col]) ? fr : floor_store[col];
      if (top <= bot) begin
        push_span(col, top, bot, SOLID_COLOR, SPAN_SOLID);
        ceil_store[col] = top;
        floor_store[col] = bot;
      end
    end else if (it.d.wall_kind == WALL_PORTAL) begin
      if (ncr > cr) begin
        top = (cr > ceil_store[col]) ? cr : ceil_store[col];
        bot = (ncr < floor_store[col]) ? ncr : floor_store[col];
        if (top < bot) begin
          push_span(col, top, bot, PORTAL_COLOR, SPAN_PORTAL);
          ceil_store[col] = bot;
        end else begin
          ceil_store[col] = top;
        end
      end
      if (nfr < fr) begin
        lb = (nfr > ceil_store[col]) ? nfr : ceil_store[col];
        lt = (fr < floor_store[col]) ? fr : floor_store[col];
        if (lb < lt) begin
          push_span(col, lb, lt, PORTAL_COLOR, SPAN_PORTAL);
          floor_store[col] = lb;
        end else begin
          floor_store[col] = lt;
        end
      end
    end
    if (span_expect.size() > base) begin
      s = span_expect.pop_back();
      s.last = 1'b1;
      span_expect.push_back(s);
    end
  endfunction

  // input side: hold an item until its transfer, then maybe idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_column_spans(presented);
        if (presented.op == OP_CLEAR) clears_sent++;
        else columns_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (col_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          presented = col_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= presented.d;
          in_tuser <= presented.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: check each span transfer against the oldest expected span
  always @(posedge clk) begin
    out_data_t od;
    span_t     e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        od = out_tdata;
        if (span_expect.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%t: unexpected span x=%0d top=%0d bot=%0d color=%h kind=%0d last=%b",
                     $realtime, od.span_x, od.span_top, od.span_bottom, od.span_color,
                     out_tuser, out_tlast);
        end else begin
          e = span_expect.pop_front();
          spans_checked++;
          if (od.span_x !== e.x || od.span_top !== e.top || od.span_bottom !== e.bot ||
              od.span_color !== e.color || out_tuser !== e.kind || out_tlast !== e.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%t: span mismatch exp x=%0d top=%0d bot=%0d color=%h kind=%0d last=%b",
                       $realtime, e.x, e.top, e.bot, e.color, e.kind, e.last,
                       "\n    got x=%0d top=%0d bot=%0d color=%h kind=%0d last=%b",
                       od.span_x, od.span_top, od.span_bottom, od.span_color, out_tuser,
                       out_tlast);
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic queue_item(opcode_t op, int col, int fr, int cr, logic [1:0] kind,
                            int nfr, int ncr, logic [31:0] color);
    col_item_t it;
    it.op = op;
    it.d.rsvd = '0;
    it.d.column = col[8:0];
    it.d.floor_row = fr[15:0];
    it.d.ceiling_row = cr[15:0];
    it.d.wall_kind = kind;
    it.d.next_floor_row = nfr[15:0];
    it.d.next_ceiling_row = ncr[15:0];
    it.d.side_color = color;
    col_items.push_back(it);
  endtask

  // mostly near-to-far style column items within the canvas, some wild rows and clears
  task automatic queue_random_item();
    int r, lim, col, cr, fr, ncr, nfr;
    r = $urandom_range(0, 99);
    lim = int'(canvas_h_m);
    if (lim < 16) lim = 16;
    if (lim > 800) lim = 800;
    col = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 15);
    if (r < 16) begin
      cr = $urandom_range(0, 65535);
      fr = $urandom_range(0, 65535);
      ncr = $urandom_range(0, 65535);
      nfr = $urandom_range(0, 65535);
    end else begin
      cr = int'($urandom_range(0, lim / 2)) - 4;
      fr = int'($urandom_range(lim / 2, lim + 4));
      ncr = cr + int'($urandom_range(0, 32)) - 8;
      nfr = fr - int'($urandom_range(0, 32)) + 8;
    end
    queue_item((r < 4) ? OP_CLEAR : OP_COLUMN, col, fr, cr, 2'($urandom_range(0, 3)),
               nfr, ncr, $urandom());
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SCALE_X:       scale_x_m = val[3:0];
      REG_SCALE_Y:       scale_y_m = val[3:0];
      REG_WIN_COLS:      win_w_m = val;
      REG_WIN_ROWS:      win_h_m = val;
      REG_CANVAS_HEIGHT: canvas_h_m = val;
      default: ;
    endcase
  endtask

  // sender holds off until every span is back and clears have had time to finish
  task automatic wait_quiet();
    @(negedge clk);
    while (col_items.size() != 0 || in_tvalid || span_expect.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_setting(int sx, int sy, int ww, int wh, int ch, int n);
    write_reg(REG_SCALE_X, CFG_DW'(sx));
    write_reg(REG_SCALE_Y, CFG_DW'(sy));
    write_reg(REG_WIN_COLS, CFG_DW'(ww));
    write_reg(REG_WIN_ROWS, CFG_DW'(wh));
    write_reg(REG_CANVAS_HEIGHT, CFG_DW'(ch));
    settings_run++;
    queue_item(OP_CLEAR, 0, 0, 0, WALL_SOLID, 0, 0, '0);
    repeat (n) queue_random_item();
    wait_quiet();
  endtask

  initial begin
    scale_x_m = SCALE_X_RST;
    scale_y_m = SCALE_Y_RST;
    win_w_m = WIN_COLS_RST;
    win_h_m = WIN_ROWS_RST;
    canvas_h_m = CANVAS_HEIGHT_RST;
    clear_clip_store();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset registers, canvas 200 rows, window 640 x 400
    queue_item(OP_COLUMN, 0, 150, 50, WALL_SOLID, 0, 0, 32'h0000_0000);
    queue_item(OP_COLUMN, 1, 160, 40, WALL_PORTAL, 140, 60, 32'hFFFF_FFFF);
    queue_item(OP_COLUMN, 2, 170, 30, WALL_DOOR, 100, 100, 32'h1234_5678);
    queue_item(OP_COLUMN, 3, 120, 60, WALL_KIND_SPARE, 90, 90, 32'h89AB_CDEF);
    queue_item(OP_COLUMN, 4, 180, -100, WALL_SOLID, 0, 0, 32'h5555_AAAA);
    queue_item(OP_COLUMN, 5, 32767, 32767, WALL_PORTAL, -32768, -32768, 32'hAAAA_5555);
    queue_item(OP_COLUMN, 6, -32768, -32768, WALL_PORTAL, 32767, 32767, 32'h0F0F_F0F0);
    queue_item(OP_COLUMN, 511, 190, 10, WALL_PORTAL, 150, 20, 32'hF0F0_0F0F);
    // floor row below the clip floor gives no floor span
    queue_item(OP_COLUMN, 7, 500, 30, WALL_SOLID, 0, 0, 32'h0000_00FF);
    queue_item(OP_COLUMN, 0, 150, 50, WALL_DOOR, 0, 0, 32'hFF00_0000);
    // rows already covered by the clip store: nothing comes out
    queue_item(OP_COLUMN, 0, 160, 40, WALL_DOOR, 0, 0, 32'h0000_FF00);
    queue_item(OP_COLUMN, 8, 100, 100, WALL_PORTAL, 100, 100, 32'h00FF_0000);
    queue_item(OP_COLUMN, 9, 120, 80, WALL_PORTAL, 130, 60, 32'h7777_7777);
    queue_item(OP_CLEAR, 511, -1, -1, WALL_KIND_SPARE, -1, -1, 32'hFFFF_FFFF);
    queue_item(OP_COLUMN, 0, 150, 50, WALL_SOLID, 0, 0, 32'h1111_1111);
    queue_item(OP_COLUMN, 10, -5, -5, WALL_SOLID, 0, 0, 32'h2222_2222);
    wait_quiet();

    run_setting(1, 1, 4096, 4096, 4096, 60);
    run_setting(8, 8, 1, 1, 1, 30);
    run_setting(2, 2, 640, 400, 200, 70);
    send_idle_pct = 76;
    recv_stall_pct = 26;
    run_setting(8, 1, 4096, 480, 240, 60);
    run_setting(0, 0, 0, 0, 0, 20);
    run_setting(15, 15, 8191, 8191, 8191, 50);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_setting(0, 3, 800, 600, 300, 70);
    run_setting(3, 1, 1000, 700, 300, 60);

    if (span_expect.size() != 0) fail_count++;
    $display("run covered %0d column items and %0d clears over %0d register settings",
             columns_sent, clears_sent, settings_run);
    $display("%0d spans compared, %0d mismatches", spans_checked, fail_count);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

endmodule

[files.f]
src/csoc_pkg.sv
src/csoc_cfg.sv
src/csoc_ctrl.sv
src/csoc_datapath.sv
src/column_span_occlusion_clipper_top.sv
src/csoc_checker.sv
verif/testbench.sv
